>>> hw/rtl/dvpu_pkg.sv
// dvpu_pkg: shared types and constants for the damped Verlet particle update.
// Used by dvpu_ctrl, dvpu_dp and damped_verlet_particle_update.
package dvpu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DAMP_W    = 17;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int ROOT_N    = 32;
    localparam int CNT_W     = 5;

    localparam logic [DAMP_W-1:0] DAMP_ONE   = DAMP_W'(65536);
    localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(39322);
    localparam logic [FRAC_BITS-1:0] ACC_K =
        FRAC_BITS'(((3 * (2 ** FRAC_BITS)) + 50) / 100);

    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_N - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        FN_ADD    = 3'd0,
        FN_STEP   = 3'd1,
        FN_LDPOS  = 3'd2,
        FN_LDPREV = 3'd3,
        FN_CLR    = 3'd4
    } t_func;

    typedef struct packed {
        logic       cap;
        logic       exec;
        logic       clr;
        logic       sq;
        logic       rinit;
        logic       rstep;
        logic       dinit;
        logic       dstep;
        logic       dstore;
        logic       upd;
        logic       oload;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       zero;
        logic       is_step;
    } t_stat;

endpackage

>>> hw/rtl/dvpu_dp.sv
// dvpu_dp: particle state, force accumulator, square-root and divide units.
// Depends on dvpu_pkg; driven by commands from dvpu_ctrl.
module dvpu_dp import dvpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_cfg_we,
    input  logic [DAMP_W-1:0] i_cfg_data,
    input  logic [2:0]        i_func,
    input  t_word             i_value_x,
    input  t_word             i_value_y,
    input  t_word             i_value_z,
    output t_word             o_pos_x,
    output t_word             o_pos_y,
    output t_word             o_pos_z
);

    t_word r_pos [3];
    t_word r_prev [3];
    t_word r_frc [3];
    t_word r_acc [3];
    logic signed [33:0] r_vel [3];
    t_word r_val [3];
    logic [2:0] r_func;
    logic [DAMP_W-1:0] r_damp;
    logic [63:0] r_sum;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [32:0] r_drem;
    logic [QUO_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_q;
    t_word r_out [3];

    logic [DAMP_W-1:0] scale;
    t_word f_sel;
    logic [63:0] fsq;
    logic signed [32:0] dlt;
    logic [32:0] dmag;
    logic [49:0] vprod;
    logic [33:0] vmag;
    logic [35:0] rem_t;
    logic [35:0] trial;
    logic r_ge;
    logic [31:0] fmag;
    logic [32:0] dt;
    logic d_ge;
    logic [QUO_W+FRAC_BITS-1:0] aprod;
    logic [QUO_W-1:0] amag;
    logic signed [35:0] nsum [3];
    t_word npos [3];
    logic signed [32:0] fadd [3];
    t_word fsat [3];

    assign scale = (r_damp > DAMP_ONE) ? '0 : DAMP_ONE - r_damp;
    assign f_sel = r_frc[i_cmd.idx];
    assign fsq   = 64'(fmag) * 64'(fmag);
    assign dlt   = 33'(r_pos[i_cmd.idx]) - 33'(r_prev[i_cmd.idx]);
    assign dmag  = dlt[32] ? 33'(-dlt) : 33'(dlt);
    assign vprod = 50'(dmag) * 50'(scale);
    assign vmag  = vprod[49:16];

    assign rem_t = {r_rem, r_rad[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign r_ge  = rem_t >= trial;

    assign fmag  = f_sel[WORD_W-1] ? 32'(-f_sel) : 32'(f_sel);
    assign dt    = {r_drem[31:0], r_dsh[QUO_W-1]};
    assign d_ge  = dt >= {1'b0, r_root};
    assign aprod = (QUO_W+FRAC_BITS)'(r_q) * (QUO_W+FRAC_BITS)'(ACC_K);
    assign amag  = aprod[QUO_W+FRAC_BITS-1:FRAC_BITS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nsum[i] = 36'(r_pos[i]) + 36'(r_vel[i]) + (36'(r_acc[i]) <<< 1);
            if (nsum[i] > 36'sh07FFFFFFF) begin
                npos[i] = t_word'(32'h7FFFFFFF);
            end else if (nsum[i] < -36'sh080000000) begin
                npos[i] = t_word'(32'h80000000);
            end else begin
                npos[i] = nsum[i][31:0];
            end
            fadd[i] = 33'(r_frc[i]) + 33'(r_val[i]);
            if (fadd[i][32] != fadd[i][31]) begin
                fsat[i] = fadd[i][32] ? t_word'(32'h80000000) : t_word'(32'h7FFFFFFF);
            end else begin
                fsat[i] = fadd[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp <= DAMP_RESET;
            for (int i = 0; i < 3; i++) begin
                r_pos[i]  <= '0;
                r_prev[i] <= '0;
                r_frc[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_damp <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                unique case (t_func'(r_func))
                    FN_ADD: begin
                        for (int i = 0; i < 3; i++) r_frc[i] <= fsat[i];
                    end
                    FN_LDPOS: begin
                        for (int i = 0; i < 3; i++) r_pos[i] <= r_val[i];
                    end
                    FN_LDPREV: begin
                        for (int i = 0; i < 3; i++) r_prev[i] <= r_val[i];
                    end
                    FN_CLR: begin
                        for (int i = 0; i < 3; i++) r_frc[i] <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.upd) begin
                for (int i = 0; i < 3; i++) begin
                    r_prev[i] <= r_pos[i];
                    r_pos[i]  <= npos[i];
                    r_frc[i]  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func   <= i_func;
            r_val[0] <= i_value_x;
            r_val[1] <= i_value_y;
            r_val[2] <= i_value_z;
        end
        if (i_cmd.clr) begin
            r_sum <= '0;
            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
        end
        if (i_cmd.sq) begin
            r_sum <= r_sum + fsq;
            r_vel[i_cmd.idx] <= dlt[32] ? 34'(-$signed({1'b0, vmag})) : $signed(vmag);
        end
        if (i_cmd.rinit) begin
            r_rad  <= r_sum;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.rstep) begin
            r_rad  <= r_rad << 2;
            r_rem  <= r_ge ? 34'(rem_t - trial) : rem_t[33:0];
            r_root <= {r_root[30:0], r_ge};
        end
        if (i_cmd.dinit) begin
            r_drem <= {1'b0, fmag[31:1]};
            r_dsh  <= {fmag[0], {FRAC_BITS{1'b0}}};
            r_q    <= '0;
        end
        if (i_cmd.dstep) begin
            r_drem <= d_ge ? dt - {1'b0, r_root} : dt;
            r_dsh  <= r_dsh << 1;
            r_q    <= {r_q[QUO_W-2:0], d_ge};
        end
        if (i_cmd.dstore) begin
            r_acc[i_cmd.idx] <= f_sel[WORD_W-1] ? t_word'(-$signed(32'(amag)))
                                                : t_word'(amag);
        end
        if (i_cmd.oload) begin
            for (int i = 0; i < 3; i++) r_out[i] <= r_pos[i];
        end
    end

    assign o_stat.zero    = (r_sum == '0);
    assign o_stat.is_step = (r_func == FN_STEP);
    assign o_pos_x = r_out[0];
    assign o_pos_y = r_out[1];
    assign o_pos_z = r_out[2];

endmodule

>>> hw/rtl/dvpu_ctrl.sv
// dvpu_ctrl: sequencer for item handling and the step computation.
// Depends on dvpu_pkg; commands dvpu_dp.
module dvpu_ctrl import dvpu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_SQ    = 10'b0000000100,
        S_RINI  = 10'b0000001000,
        S_ROOT  = 10'b0000010000,
        S_DINI  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_DST   = 10'b0010000000,
        S_UPD   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0] r_idx, n_idx;
    logic r_ovld, n_ovld;
    logic slot_free;

    assign slot_free = !r_ovld || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_ovld  = r_ovld && i_out_stall;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.is_step) begin
                    o_cmd.clr = 1'b1;
                    n_idx = '0;
                    n_state = S_SQ;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                if (r_idx == 2'd2) begin
                    n_state = S_RINI;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_RINI: begin
                if (i_stat.zero) begin
                    o_cmd.upd = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rinit = 1'b1;
                    n_cnt = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.rstep = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    n_idx = '0;
                    n_state = S_DINI;
                end
            end
            S_DINI: begin
                o_cmd.dinit = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DST;
                end
            end
            S_DST: begin
                o_cmd.dstore = 1'b1;
                if (r_idx == 2'd2) begin
                    n_state = S_UPD;
                end else begin
                    n_idx = r_idx + 2'd1;
                    n_state = S_DINI;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.oload = 1'b1;
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ovld  <= n_ovld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;

endmodule

>>> hw/rtl/damped_verlet_particle_update.sv
// damped_verlet_particle_update: top level of the one-particle Verlet update.
// Depends on dvpu_pkg, dvpu_ctrl and dvpu_dp.
//
// Input channel: i_in_valid / o_in_stall with i_func and i_value_x/y/z.
// Output channel: o_out_valid / i_out_stall with o_pos_x/y/z, one item out
// for every item in, in order. Configuration: i_cfg_we writes i_cfg_data
// into the damping register in the same edge.
// Add force, load and clear items are executed and then loaded into the result
// register. A step with zero force squares the force and then updates. A step
// with nonzero force squares the force per axis, takes the bit-per-cycle square
// root, then runs three divides through one shared restoring divider, one per
// axis with FRAC_BITS + 1 quotient bits each, plus the update.
// One item is in work at a time; o_in_stall is high from acceptance until the
// result enters the output register. A finished result waits in the output
// register while the receiver stalls, and the next item may be accepted then.
// Reset clears position, previous position and force, and sets damping to 0.6.
module damped_verlet_particle_update import dvpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_func,
    input  t_word             i_value_x,
    input  t_word             i_value_y,
    input  t_word             i_value_z,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_word             o_pos_x,
    output t_word             o_pos_y,
    output t_word             o_pos_z,
    input  logic              i_cfg_we,
    input  logic [DAMP_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    dvpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dvpu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_func     (i_func),
        .i_value_x  (i_value_x),
        .i_value_y  (i_value_y),
        .i_value_z  (i_value_z),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_pos_z    (o_pos_z)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block idle right after accepting an item");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    a_no_load_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && !o_in_stall) |=> o_out_valid)
        else $error("waiting result dropped");

endmodule

>>> tb/sv/damped_verlet_particle_update_test.sv
// damped_verlet_particle_update_test: self-checking bench for the one-particle
// Verlet update; a directed table, then random bursts, checked against a model.
// Depends on dvpu_pkg and damped_verlet_particle_update.
`timescale 1ns / 100ps

module damped_verlet_particle_update_test import dvpu_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0] func;
        t_word      vx, vy, vz;
        logic       known;
        t_word      ex, ey, ez;
    } t_row;

    typedef struct {
        t_word px, py, pz;
    } t_pos;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_func;
    t_word             i_value_x, i_value_y, i_value_z;
    logic              o_out_valid;
    logic              i_out_stall;
    t_word             o_pos_x, o_pos_y, o_pos_z;
    logic              i_cfg_we;
    logic [DAMP_W-1:0] i_cfg_data;

    damped_verlet_particle_update uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_value_x   (i_value_x),
        .i_value_y   (i_value_y),
        .i_value_z   (i_value_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    t_word             m_pos[3];
    t_word             m_prev[3];
    t_word             m_force[3];
    logic [DAMP_W-1:0] m_damp;

    t_pos   pos_expected[$];
    int     n_errors;
    int     cycle_count = 0;
    logic   long_hold;
    logic   random_stall;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_word clamp32(longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(64'sh80000000)) return 32'sh80000000;
        return t_word'(v);
    endfunction

    function automatic longint root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void verlet_step();
        longint unsigned s;
        longint acc[3];
        longint len, u, scale, p, d, v;
        longint k;
        k = longint'(ACC_K);
        s = 0;
        for (int i = 0; i < 3; i++) begin
            acc[i] = 0;
            s += longint'(m_force[i]) * longint'(m_force[i]);
        end
        if (s != 0) begin
            len = root64(s);
            for (int i = 0; i < 3; i++) begin
                u = (longint'(m_force[i]) <<< FRAC_BITS) / len;
                acc[i] = (u * k) / (longint'(1) <<< FRAC_BITS);
            end
        end
        scale = 65536 - ((m_damp > DAMP_ONE) ? 65536 : longint'(m_damp));
        for (int i = 0; i < 3; i++) begin
            p = m_pos[i];
            d = p - longint'(m_prev[i]);
            v = (d * scale) / 65536;
            m_prev[i]  = m_pos[i];
            m_pos[i]   = clamp32(p + v + 2 * acc[i]);
            m_force[i] = 0;
        end
    endfunction

    function automatic t_pos particle_apply(logic [2:0] f, t_word vx, t_word vy, t_word vz);
        t_word val[3];
        t_pos  r;
        val = '{vx, vy, vz};
        case (f)
            FN_ADD: begin
                for (int i = 0; i < 3; i++)
                    m_force[i] = clamp32(longint'(m_force[i]) + longint'(val[i]));
            end
            FN_STEP:   verlet_step();
            FN_LDPOS:  m_pos = val;
            FN_LDPREV: m_prev = val;
            FN_CLR: begin
                for (int i = 0; i < 3; i++) m_force[i] = 0;
            end
            default: ;
        endcase
        r.px = m_pos[0];
        r.py = m_pos[1];
        r.pz = m_pos[2];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("error at cycle %0d: %s", cycle_count, msg);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pos_expected.size() == 0) begin
                report_mismatch("unexpected item");
            end else begin
                t_pos e;
                e = pos_expected.pop_front();
                if (o_pos_x !== e.px)
                    report_mismatch($sformatf("pos_x got %h want %h", o_pos_x, e.px));
                if (o_pos_y !== e.py)
                    report_mismatch($sformatf("pos_y got %h want %h", o_pos_y, e.py));
                if (o_pos_z !== e.pz)
                    report_mismatch($sformatf("pos_z got %h want %h", o_pos_z, e.pz));
            end
        end
    end

    // receiver: own stall pattern plus an optional long hold-off
    initial begin
        random_stall = 1'b0;
        i_out_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            case ($urandom_range(0, 3))
                0: random_stall = 1'b0;
                1: random_stall = ($urandom_range(0, 3) == 0);
                default: random_stall = ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 40) == 0) begin
                repeat ($urandom_range(20, 60)) begin
                    i_out_stall <= 1'b0 | long_hold;
                    @(negedge i_clk);
                end
            end
            i_out_stall <= random_stall | long_hold;
        end
    end

    task automatic send_item(logic [2:0] f, t_word vx, t_word vy, t_word vz,
                             logic known, t_word ex, t_word ey, t_word ez);
        t_pos p;
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_value_x  <= vx;
        i_value_y  <= vy;
        i_value_z  <= vz;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = particle_apply(f, vx, vy, vz);
        if (known && (p.px !== ex || p.py !== ey || p.pz !== ez)) begin
            report_mismatch($sformatf("directed row expectation %h %h %h", ex, ey, ez));
        end
        if (known) begin
            p.px = ex;
            p.py = ey;
            p.pz = ez;
        end
        pos_expected.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        while (pos_expected.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_damping(logic [DAMP_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        m_damp = d;
    endtask

    function automatic t_word rand_word(int mode);
        case (mode)
            0: return t_word'($urandom());
            1: return t_word'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
            2: return t_word'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
            default: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    task automatic random_phase(int n);
        int sent, burst, mode;
        logic [2:0] f;
        int r;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < n; b++) begin
                r = $urandom_range(0, 99);
                if (r < 40) f = FN_ADD;
                else if (r < 70) f = FN_STEP;
                else if (r < 80) f = FN_LDPOS;
                else if (r < 88) f = FN_LDPREV;
                else if (r < 95) f = FN_CLR;
                else f = 3'($urandom_range(5, 7));
                mode = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(0, 3);
                send_item(f, rand_word(mode), rand_word(mode), rand_word(mode), 0, 0, 0, 0);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    endtask

    t_row rows[$];

    initial begin
        n_errors     = 0;
        long_hold    = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = '0;
        i_value_x    = '0;
        i_value_y    = '0;
        i_value_z    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        m_damp       = DAMP_RESET;
        for (int i = 0; i < 3; i++) begin
            m_pos[i] = 0;
            m_prev[i] = 0;
            m_force[i] = 0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        rows = '{
            '{FN_STEP,   0, 0, 0, 1, 0, 0, 0},
            '{3'd5,      -1, -1, -1, 1, 0, 0, 0},
            '{FN_LDPOS,  32'sh7fffffff, 32'sh80000000, 0, 1,
              32'sh7fffffff, 32'sh80000000, 0},
            '{FN_LDPREV, 32'sh80000000, 32'sh7fffffff, 0, 1,
              32'sh7fffffff, 32'sh80000000, 0},
            '{FN_STEP,   0, 0, 0, 0, 0, 0, 0},
            '{FN_ADD,    32'sh7fffffff, 32'sh80000000, 5, 0, 0, 0, 0},
            '{FN_ADD,    32'sh7fffffff, 32'sh80000000, -5, 0, 0, 0, 0},
            '{FN_STEP,   0, 0, 0, 0, 0, 0, 0},
            '{FN_LDPOS,  32'sh00010000, -32'sh00020000, 32'sh00030000, 1,
              32'sh00010000, -32'sh00020000, 32'sh00030000},
            '{FN_LDPREV, 0, 0, 0, 0, 0, 0, 0},
            '{FN_ADD,    32'sh00010000, 0, 0, 0, 0, 0, 0},
            '{FN_CLR,    -1, -1, -1, 0, 0, 0, 0},
            '{FN_STEP,   0, 0, 0, 0, 0, 0, 0},
            '{FN_ADD,    0, 0, -32'sh00000001, 0, 0, 0, 0},
            '{FN_STEP,   0, 0, 0, 0, 0, 0, 0},
            '{FN_ADD,    32'sh12345678, -32'sh0abcdef0, 32'sh00000003, 0, 0, 0, 0},
            '{FN_STEP,   0, 0, 0, 0, 0, 0, 0},
            '{3'd6,      32'sh55555555, 32'sh2aaaaaaa, -1, 0, 0, 0, 0},
            '{3'd7,      0, 0, 0, 0, 0, 0, 0},
            '{FN_STEP,   0, 0, 0, 0, 0, 0, 0}
        };
        foreach (rows[k])
            send_item(rows[k].func, rows[k].vx, rows[k].vy, rows[k].vz,
                      rows[k].known, rows[k].ex, rows[k].ey, rows[k].ez);
        go_idle();

        write_damping(DAMP_W'(0));
        random_phase(150);
        go_idle();
        write_damping(DAMP_W'(17'h1ffff));
        random_phase(100);
        go_idle();
        write_damping(DAMP_ONE);
        random_phase(100);
        go_idle();
        write_damping(DAMP_W'($urandom_range(1, 65535)));

        // long receiver hold-off while items keep coming
        long_hold = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end
            random_phase(20);
        join
        random_phase(230);
        go_idle();

        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
